/* src/cartesian_mesh_connectivity_query_core_assert.svh */
// assertion helpers for the mesh connectivity query core
`ifndef CARTESIAN_MESH_CONNECTIVITY_QUERY_CORE_ASSERT_SVH
`define CARTESIAN_MESH_CONNECTIVITY_QUERY_CORE_ASSERT_SVH

// same-cycle implication
`define CMCQ_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("cmcq assertion failed");

// next-cycle implication
`define CMCQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cmcq assertion failed");

`endif

/* src/cmcq_pkg.sv */
package cmcq_pkg;

  localparam int unsigned ID_W              = 26;
  localparam int unsigned OP_W              = 2;
  localparam int unsigned REG_W             = 13;
  localparam int unsigned MAX_CELLS_DEFAULT = 4096;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [REG_W-1:0] ACROSS_RESET = 13'd4;
  localparam logic [REG_W-1:0] DOWN_RESET   = 13'd3;

  typedef enum logic [OP_W-1:0] {
    OP_NODE_CELLS = 2'd0,
    OP_FACE_CELLS = 2'd1,
    OP_CELL_NBRS  = 2'd2,
    OP_CELL_FACES = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_CELLS_ACROSS = 1'b0,
    CFG_CELLS_DOWN   = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_BUILD,
    BK_EMIT
  } back_state_e;

  // classified query as it sits in the queue
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic            bad;
  } query_t;

endpackage

/* src/cmcq_queue.sv */
module cmcq_queue #(
  parameter int unsigned DEPTH = cmcq_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  cmcq_pkg::query_t             data_i,
  input  logic                         pop_i,
  output cmcq_pkg::query_t             data_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  import cmcq_pkg::*;

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  query_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

/* src/cmcq_front.sv */
module cmcq_front #(
  parameter int unsigned MAX_CELLS_PER_SIDE = cmcq_pkg::MAX_CELLS_DEFAULT,
  parameter int unsigned DEPTH              = cmcq_pkg::QUEUE_DEPTH
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [cmcq_pkg::OP_W-1:0]                opcode_i,
  input  logic [cmcq_pkg::ID_W-1:0]                query_id_i,
  input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0]  w_i,
  input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0]  h_i,
  input  logic [$clog2(DEPTH+1)-1:0]               queue_count_i,
  output logic                                     busy_o,
  output logic                                     push_o,
  output cmcq_pkg::query_t                         push_data_o
);
  import cmcq_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_CELLS_PER_SIDE+1);
  localparam int unsigned CW   = (2*WW+2 > ID_W+1) ? 2*WW+2 : ID_W+1;
  localparam int unsigned CNTW = $clog2(DEPTH+1);

  logic            s1_valid_q;
  op_e             s1_op_q;
  logic [ID_W-1:0] s1_id_q;
  logic [CW-1:0]   s1_wh_q;
  logic [CW-1:0]   wx, hx, limit;
  logic            accept;

  // hold off while the queue could not take what is in flight
  assign busy_o = ((CNTW+1)'(queue_count_i) + (CNTW+1)'(s1_valid_q)) >= (CNTW+1)'(DEPTH);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // register the transaction and the cell count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= op_e'(opcode_i);
      s1_id_q <= query_id_i;
      s1_wh_q <= CW'(w_i) * CW'(h_i);
    end
  end

  // id range check per opcode
  always_comb begin
    wx = CW'(w_i);
    hx = CW'(h_i);
    case (s1_op_q)
      OP_NODE_CELLS: limit = s1_wh_q + wx + hx + CW'(1);
      OP_FACE_CELLS: limit = (s1_wh_q << 1) + wx + hx;
      default:       limit = s1_wh_q;
    endcase
  end

  assign push_o            = s1_valid_q;
  assign push_data_o.op    = s1_op_q;
  assign push_data_o.id    = s1_id_q;
  assign push_data_o.bad   = CW'(s1_id_q) >= limit;

endmodule

/* src/cmcq_back.sv */
module cmcq_back #(
  parameter int unsigned MAX_CELLS_PER_SIDE = cmcq_pkg::MAX_CELLS_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0]  w_i,
  input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0]  h_i,
  input  logic                                     q_valid_i,
  input  cmcq_pkg::query_t                         q_data_i,
  output logic                                     pop_o,
  output logic                                     result_valid_o,
  output logic [cmcq_pkg::ID_W-1:0]                result_id_o,
  output logic                                     present_o,
  output logic                                     bad_id_o,
  output logic                                     last_o
);
  import cmcq_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_CELLS_PER_SIDE+1);
  localparam int unsigned QW   = WW;
  localparam int unsigned DW   = ID_W + QW;
  localparam int unsigned CW   = (2*WW+2 > ID_W+1) ? 2*WW+2 : ID_W+1;
  localparam int unsigned CNTW = $clog2(QW);

  back_state_e     state_q, state_d;
  op_e             op_q;
  logic            bad_q;
  logic [ID_W-1:0] rem_q;
  logic [DW-1:0]   dsh_q;
  logic [QW-1:0]   quo_q;
  logic [CNTW-1:0] cnt_q;
  logic [CW-1:0]   iw_q;
  logic [ID_W-1:0] slot_q [4];
  logic [3:0]      mask_q;

  logic [WW+1:0]   divisor;
  logic            ge;
  logic [CW-1:0]   i, j, wx, hx, iwm, half, b;
  logic [CW-1:0]   s [4];
  logic [3:0]      m;
  logic [3:0]      pick;
  logic [1:0]      sel;

  // divisor for the row split
  always_comb begin
    case (q_data_i.op)
      OP_NODE_CELLS: divisor = (WW+2)'(w_i) + 1'b1;
      OP_FACE_CELLS: divisor = ((WW+2)'(w_i) << 1) + 1'b1;
      default:       divisor = (WW+2)'(w_i);
    endcase
  end

  assign ge = DW'(rem_q) >= dsh_q;

  // candidate ids and their presence
  always_comb begin
    i    = CW'(quo_q);
    j    = CW'(rem_q);
    wx   = CW'(w_i);
    hx   = CW'(h_i);
    iwm  = iw_q - wx;
    half = j >> 1;
    b    = (j << 1) + (iw_q << 1) + i;
    for (int k = 0; k < 4; k++) begin
      s[k] = '0;
    end
    m = '0;
    case (op_q)
      OP_NODE_CELLS: begin
        s[0] = iw_q + j;
        s[1] = iw_q + j - CW'(1);
        s[2] = iwm + j;
        s[3] = iwm + j - CW'(1);
        m[0] = (i < hx) && (j < wx);
        m[1] = (i < hx) && (j != '0);
        m[2] = (i != '0) && (j < wx);
        m[3] = (i != '0) && (j != '0);
      end
      OP_FACE_CELLS: begin
        if (i < hx) begin
          if (j == (wx << 1)) begin
            s[0] = iw_q + wx - CW'(1);
            m    = 4'b0001;
          end else if (j == CW'(1)) begin
            s[0] = iw_q;
            m    = 4'b0001;
          end else if (!j[0]) begin
            s[0] = iwm + half;
            s[1] = iw_q + half;
            m    = {2'b00, 1'b1, i != '0};
          end else begin
            s[0] = iw_q + half - CW'(1);
            s[1] = iw_q + half;
            m    = 4'b0011;
          end
        end else begin
          s[0] = iwm + j;
          m    = 4'b0001;
        end
      end
      OP_CELL_NBRS: begin
        s[0] = iwm + j;
        s[1] = iw_q + wx + j;
        s[2] = iw_q + j - CW'(1);
        s[3] = iw_q + j + CW'(1);
        m[0] = i != '0;
        m[1] = (i + CW'(1)) < hx;
        m[2] = j != '0;
        m[3] = (j + CW'(1)) < wx;
      end
      default: begin
        s[0] = b;
        s[1] = b + CW'(1);
        s[2] = b + ((j == wx - CW'(1)) ? CW'(2) : CW'(3));
        s[3] = b + (((i + CW'(1)) < hx) ? ((wx << 1) + CW'(1))
                                        : ((wx << 1) + CW'(1) - j));
        m    = 4'b1111;
      end
    endcase
  end

  // lowest pending slot
  always_comb begin
    sel  = 2'd0;
    pick = 4'b0000;
    for (int k = 3; k >= 0; k--) begin
      if (mask_q[k]) begin
        sel  = 2'(k);
        pick = 4'b0001 << k;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = q_data_i.bad ? BK_EMIT : BK_DIV;
        end
      end
      BK_DIV:   state_d = (cnt_q == '0) ? BK_MUL : BK_DIV;
      BK_MUL:   state_d = BK_BUILD;
      BK_BUILD: state_d = BK_EMIT;
      BK_EMIT:  state_d = last_o ? BK_IDLE : BK_EMIT;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        op_q   <= q_data_i.op;
        bad_q  <= q_data_i.bad;
        rem_q  <= q_data_i.id;
        dsh_q  <= DW'(divisor) << (QW-1);
        quo_q  <= '0;
        cnt_q  <= CNTW'(QW-1);
        mask_q <= '0;
      end
      BK_DIV: begin
        quo_q <= {quo_q[QW-2:0], ge};
        if (ge) begin
          rem_q <= ID_W'(DW'(rem_q) - dsh_q);
        end
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q - 1'b1;
      end
      BK_MUL: begin
        iw_q <= CW'(quo_q) * CW'(w_i);
      end
      BK_BUILD: begin
        for (int k = 0; k < 4; k++) begin
          slot_q[k] <= ID_W'(s[k]);
        end
        mask_q <= m;
      end
      BK_EMIT: begin
        mask_q <= mask_q & ~pick;
      end
      default: begin
        mask_q <= '0;
      end
    endcase
  end

  // result drive
  assign result_valid_o = (state_q == BK_EMIT);
  assign present_o      = mask_q != '0;
  assign result_id_o    = present_o ? slot_q[sel] : '0;
  assign bad_id_o       = bad_q;
  assign last_o         = (mask_q & ~pick) == '0;

endmodule

/* src/cartesian_mesh_connectivity_query_core.sv */
// Connectivity queries on a structured 2D quad mesh.
// Query channel: present opcode_i and query_id_i with start_i high; the
// transaction is taken at a rising edge where busy_o is low.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (cells across, cells down) at once; write only while no query is pending.
// Result channel: result_valid_o is high for exactly one cycle per result id,
// with present_o, bad_id_o and last_o; last_o marks the final result.
// Sequence: the front end registers each accepted query into the queue;
// the back end then dequeues it, runs the restoring row division (QW =
// clog2(MAX_CELLS_PER_SIDE+1) quotient bits, 13 by default, one quotient
// bit per cycle), multiplies, builds the list and emits 1 to 4 results.
// An out-of-mesh id skips the division and goes straight to emit; the
// two-entry queue lets new queries in while earlier ones are still being
// answered.
// Reset: registers return to 4 cells across and 3 down, the queue empties.
// The receiver cannot stall; every result is taken in the cycle it shows.
`include "cartesian_mesh_connectivity_query_core_assert.svh"

module cartesian_mesh_connectivity_query_core #(
  parameter int unsigned MAX_CELLS_PER_SIDE = cmcq_pkg::MAX_CELLS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [cmcq_pkg::OP_W-1:0]      opcode_i,
  input  logic [cmcq_pkg::ID_W-1:0]      query_id_i,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [cmcq_pkg::REG_W-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [cmcq_pkg::ID_W-1:0]      result_id_o,
  output logic                           present_o,
  output logic                           bad_id_o,
  output logic                           last_o
);
  import cmcq_pkg::*;

  localparam int unsigned WW   = $clog2(MAX_CELLS_PER_SIDE+1);
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH+1);

  logic [REG_W-1:0] across_q, down_q;
  logic [WW-1:0]    w_eff, h_eff;
  logic             push, pop;
  query_t           push_data, q_data;
  logic [CNTW-1:0]  q_count;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      across_q <= ACROSS_RESET;
      down_q   <= DOWN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CELLS_ACROSS: across_q <= cfg_wdata_i;
        CFG_CELLS_DOWN:   down_q   <= cfg_wdata_i;
        default:          across_q <= across_q;
      endcase
    end
  end

  // clamp mesh size to the supported range
  always_comb begin
    if (across_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(across_q) > MAX_CELLS_PER_SIDE) begin
      w_eff = WW'(MAX_CELLS_PER_SIDE);
    end else begin
      w_eff = WW'(across_q);
    end
    if (down_q == '0) begin
      h_eff = WW'(1);
    end else if (32'(down_q) > MAX_CELLS_PER_SIDE) begin
      h_eff = WW'(MAX_CELLS_PER_SIDE);
    end else begin
      h_eff = WW'(down_q);
    end
  end

  cmcq_front #(
    .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE),
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .opcode_i,
    .query_id_i,
    .w_i(w_eff),
    .h_i(h_eff),
    .queue_count_i(q_count),
    .busy_o,
    .push_o(push),
    .push_data_o(push_data)
  );

  cmcq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i(push),
    .data_i(push_data),
    .pop_i(pop),
    .data_o(q_data),
    .count_o(q_count)
  );

  cmcq_back #(
    .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)
  ) u_back (
    .clk_i,
    .rst_ni,
    .w_i(w_eff),
    .h_i(h_eff),
    .q_valid_i(q_count != '0),
    .q_data_i(q_data),
    .pop_o(pop),
    .result_valid_o,
    .result_id_o,
    .present_o,
    .bad_id_o,
    .last_o
  );

  // checks
  `CMCQ_ASSERT_IMP(a_bad_is_single, result_valid_o && bad_id_o, last_o && !present_o)
  `CMCQ_ASSERT_IMP(a_empty_id_zero, result_valid_o && !present_o, result_id_o == '0)
  `CMCQ_ASSERT_NEXT(a_accept_pushes, start_i && !busy_o, push)
  `CMCQ_ASSERT_IMP(a_queue_bound, push, q_count < CNTW'(QUEUE_DEPTH) || pop)

endmodule

/* verif/cartesian_mesh_connectivity_query_core_checker.sv */
module cartesian_mesh_connectivity_query_core_checker #(
  parameter int unsigned MAX_CELLS_PER_SIDE = cmcq_pkg::MAX_CELLS_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [cmcq_pkg::OP_W-1:0]  opcode_i,
  input  logic [cmcq_pkg::ID_W-1:0]  query_id_i,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [cmcq_pkg::REG_W-1:0] cfg_wdata_i,
  input  logic                       result_valid_i,
  input  logic [cmcq_pkg::ID_W-1:0]  result_id_i,
  input  logic                       present_i,
  input  logic                       bad_id_i,
  input  logic                       last_i,
  output int                         err_count_o,
  output int                         pending_o
);
  import cmcq_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            present;
    logic            bad;
    logic            last;
  } answer_t;

  answer_t           answers_q[$];
  logic [REG_W-1:0]  across_reg;
  logic [REG_W-1:0]  down_reg;

  // print one mismatch line and count it
  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count_o++;
  endtask

  // clamp a register to its usable range
  function automatic longint unsigned clamp_size(input logic [REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_CELLS_PER_SIDE) return MAX_CELLS_PER_SIDE;
    return r;
  endfunction

  function automatic void push_id(input longint unsigned v);
    answer_t a;
    a.id      = v[ID_W-1:0];
    a.present = 1'b1;
    a.bad     = 1'b0;
    a.last    = 1'b0;
    answers_q.push_back(a);
  endfunction

  // expected answer list of one query
  function automatic void predict_answers(input op_e op, input logic [ID_W-1:0] qid);
    longint unsigned w, h, id, i, j, f, row, bottom;
    int              first;
    answer_t         a;
    w     = clamp_size(across_reg);
    h     = clamp_size(down_reg);
    id    = qid;
    first = answers_q.size();
    a     = '0;
    a.last = 1'b1;
    case (op)
      OP_NODE_CELLS: begin
        if (id >= (w + 1) * (h + 1)) begin
          a.bad = 1'b1;
          answers_q.push_back(a);
          return;
        end
        i = id / (w + 1);
        j = id - i * (w + 1);
        if (i < h && j < w) push_id(i * w + j);
        if (i < h && j > 0) push_id(i * w + j - 1);
        if (i > 0 && j < w) push_id((i - 1) * w + j);
        if (i > 0 && j > 0) push_id((i - 1) * w + j - 1);
      end
      OP_FACE_CELLS: begin
        if (id >= 2 * w * h + w + h) begin
          a.bad = 1'b1;
          answers_q.push_back(a);
          return;
        end
        row = 2 * w + 1;
        i   = id / row;
        f   = id - i * row;
        if (i < h) begin
          if (f == 2 * w) push_id(i * w + w - 1);
          else if (f == 1) push_id(i * w);
          else if (f[0] == 1'b0) begin
            if (i > 0) push_id((i - 1) * w + f / 2);
            push_id(i * w + f / 2);
          end else begin
            push_id(i * w + (f - 1) / 2 - 1);
            push_id(i * w + (f - 1) / 2);
          end
        end else begin
          push_id((i - 1) * w + f);
        end
      end
      default: begin
        if (id >= w * h) begin
          a.bad = 1'b1;
          answers_q.push_back(a);
          return;
        end
        i = id / w;
        j = id - i * w;
        if (op == OP_CELL_NBRS) begin
          if (i >= 1) push_id((i - 1) * w + j);
          if (i + 1 < h) push_id((i + 1) * w + j);
          if (j >= 1) push_id(i * w + j - 1);
          if (j + 1 < w) push_id(i * w + j + 1);
        end else begin
          bottom = 2 * j + i * (2 * w + 1);
          push_id(bottom);
          push_id(bottom + 1);
          push_id(bottom + ((j == w - 1) ? 2 : 3));
          push_id(bottom + ((i + 1 < h) ? (2 * w + 1) : (2 * w + 1 - j)));
        end
      end
    endcase
    // empty list gives a single marker result
    if (answers_q.size() == first) answers_q.push_back(a);
    else answers_q[answers_q.size() - 1].last = 1'b1;
  endfunction

  // compare results, predict accepted transactions, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_a;
    if (!rst_ni) begin
      across_reg  = ACROSS_RESET;
      down_reg    = DOWN_RESET;
      answers_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (result_valid_i) begin
        if (answers_q.size() == 0) begin
          report($sformatf("result id %0d with no query outstanding", result_id_i));
        end else begin
          exp_a = answers_q.pop_front();
          if (result_id_i !== exp_a.id)
            report($sformatf("result_id %0d, expected %0d", result_id_i, exp_a.id));
          if (present_i !== exp_a.present)
            report($sformatf("present %b, expected %b", present_i, exp_a.present));
          if (bad_id_i !== exp_a.bad)
            report($sformatf("bad_id %b, expected %b", bad_id_i, exp_a.bad));
          if (last_i !== exp_a.last)
            report($sformatf("last %b, expected %b", last_i, exp_a.last));
        end
      end
      if (start_i && !busy_i) predict_answers(op_e'(opcode_i), query_id_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_CELLS_ACROSS) across_reg = cfg_wdata_i;
        else down_reg = cfg_wdata_i;
      end
      pending_o = answers_q.size();
    end
  end

endmodule

/* verif/cartesian_mesh_connectivity_query_core_test.sv */
module cartesian_mesh_connectivity_query_core_test;
  import cmcq_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [OP_W-1:0]     opcode_i;
  logic [ID_W-1:0]     query_id_i;
  logic                cfg_we_i;
  logic [0:0]          cfg_idx_i;
  logic [REG_W-1:0]    cfg_wdata_i;
  logic                result_valid_o;
  logic [ID_W-1:0]     result_id_o;
  logic                present_o;
  logic                bad_id_o;
  logic                last_o;
  int                  err_count;
  int                  pending;

  int                  gap_pct;
  int                  query_count;
  int                  setting_count;
  longint unsigned     mesh_w;
  longint unsigned     mesh_h;

  cartesian_mesh_connectivity_query_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .query_id_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_o, .result_id_o,
    .present_o, .bad_id_o, .last_o
  );

  cartesian_mesh_connectivity_query_core_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .opcode_i, .query_id_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_i(result_valid_o),
    .result_id_i(result_id_o), .present_i(present_o), .bad_id_i(bad_id_o),
    .last_i(last_o), .err_count_o(err_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // one query transaction, with random gaps before it
  task automatic send_query(input op_e op, input logic [ID_W-1:0] qid);
    while ($urandom_range(99) < gap_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i    = 1'b1;
    opcode_i   = op;
    query_id_i = qid;
    do @(posedge clk_i); while (busy_o);
    query_count++;
    @(negedge clk_i);
  endtask

  // drain outstanding results, then let the back end settle
  task automatic drain();
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // mesh size change, only while idle
  task automatic set_mesh(input logic [REG_W-1:0] across, input logic [REG_W-1:0] down);
    drain();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_CELLS_ACROSS;
    cfg_wdata_i = across;
    @(negedge clk_i);
    cfg_idx_i   = CFG_CELLS_DOWN;
    cfg_wdata_i = down;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    mesh_w = (across == 0) ? 1 : (across > 4096) ? 4096 : across;
    mesh_h = (down == 0) ? 1 : (down > 4096) ? 4096 : down;
    setting_count++;
  endtask

  // random query: mostly valid ids, some near the edge, some anything
  task automatic random_queries(input int count);
    op_e             op;
    longint unsigned lim, v;
    int              sel;
    repeat (count) begin
      op  = op_e'($urandom_range(3));
      lim = (op == OP_NODE_CELLS) ? (mesh_w + 1) * (mesh_h + 1) :
            (op == OP_FACE_CELLS) ? 2 * mesh_w * mesh_h + mesh_w + mesh_h :
            mesh_w * mesh_h;
      sel = $urandom_range(99);
      if (sel < 70) v = {$urandom, $urandom} % lim;
      else if (sel < 85) v = lim - 2 + $urandom_range(3);
      else v = $urandom;
      send_query(op, v[ID_W-1:0]);
    end
  endtask

  initial begin
    start_i     = 1'b0;
    opcode_i    = '0;
    query_id_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_CELLS_ACROSS;
    cfg_wdata_i = '0;
    gap_pct     = 25;
    query_count = 0;
    setting_count = 1;
    mesh_w = 4;
    mesh_h = 3;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: corners, boundary faces and out-of-mesh ids on the reset 4x3 mesh
    send_query(OP_NODE_CELLS, 0);
    send_query(OP_NODE_CELLS, 6);
    send_query(OP_NODE_CELLS, 19);
    send_query(OP_NODE_CELLS, 20);
    send_query(OP_FACE_CELLS, 0);
    send_query(OP_FACE_CELLS, 1);
    send_query(OP_FACE_CELLS, 3);
    send_query(OP_FACE_CELLS, 8);
    send_query(OP_FACE_CELLS, 11);
    send_query(OP_FACE_CELLS, 30);
    send_query(OP_FACE_CELLS, 31);
    send_query(OP_CELL_NBRS, 0);
    send_query(OP_CELL_NBRS, 5);
    send_query(OP_CELL_NBRS, 11);
    send_query(OP_CELL_FACES, 0);
    send_query(OP_CELL_FACES, 3);
    send_query(OP_CELL_FACES, 11);
    send_query(OP_CELL_FACES, 12);
    send_query(OP_CELL_NBRS, '1);

    // zero registers fall back to a single cell: empty neighbour list
    set_mesh(0, 0);
    send_query(OP_CELL_NBRS, 0);
    send_query(OP_NODE_CELLS, 3);
    // oversize registers clamp to the largest mesh
    set_mesh('1, '1);
    send_query(OP_FACE_CELLS, 33562623);
    send_query(OP_CELL_FACES, 4096 * 4096 - 1);
    send_query(OP_NODE_CELLS, '1);
    random_queries(10);

    // random part over several mesh shapes and three gap profiles
    set_mesh(1, 4096);  random_queries(15);
    set_mesh(4096, 1);  random_queries(15);
    gap_pct = 71;
    set_mesh(2, 2);     random_queries(20);
    set_mesh(5, 7);     random_queries(20);
    gap_pct = 0;
    set_mesh(1, 1);     random_queries(10);
    set_mesh(4096, 4096); random_queries(10);
    set_mesh(13'd37 + $urandom_range(200), 13'd1 + $urandom_range(60));
    random_queries(10);

    drain();
    $display("covered %0d queries on %0d mesh settings, all four opcodes,",
             query_count, setting_count);
    $display("boundary and out-of-mesh ids, sender gaps of 25, 71 and 0 percent");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
